[design/distance_aftertouch_averager_defines.svh]
// ---------------------------------------------------------------------------
// Distance aftertouch averager assertion macros
// Shared concurrent assertion forms used by the block's modules.
// ---------------------------------------------------------------------------
`ifndef DISTANCE_AFTERTOUCH_AVERAGER_DEFINES_SVH
`define DISTANCE_AFTERTOUCH_AVERAGER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DAA_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DAA_ASSERT_NXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[design/daa_pkg.sv]
// ---------------------------------------------------------------------------
// Distance aftertouch averager package
// Constants, codes and control structures shared by the block's modules.
// ---------------------------------------------------------------------------
package daa_pkg;

  localparam int DEPTH_DEF = 5;

  localparam int DIST_W = 12;
  localparam int GAIN_W = 16;
  localparam int DIV_W  = 16;
  localparam int LVL_W  = 17;

  localparam logic [LVL_W-1:0] FULL_SCALE = 17'h10000;

  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 12'd400;
  localparam logic [GAIN_W-1:0] ZERO_BOUND_RST   = 16'd4588;
  localparam logic [GAIN_W-1:0] FULL_BOUND_RST   = 16'd60948;

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_ZERO_BOUND   = 2'd1;
  localparam logic [IDX_W-1:0] REG_FULL_BOUND   = 2'd2;

  localparam logic [1:0] OP_GAIN  = 2'd0;
  localparam logic [1:0] OP_SCALE = 2'd2;

  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_FULL = 2'd1;
  localparam logic [1:0] SRC_QUOT = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic [1:0] div_op;
    logic       write_gain;
    logic       gain_zero;
    logic       mean_load;
    logic       out_load;
    logic [1:0] out_src;
  } cmd_t;

  typedef struct packed {
    logic dist_zero;
    logic dist_over;
    logic div_busy;
    logic div_done;
    logic mean_low;
    logic mean_high;
  } sts_t;

endpackage

[design/distance_aftertouch_averager.sv]
// ---------------------------------------------------------------------------
// Distance aftertouch averager
// Turns ultrasonic distance samples into a smoothed, rescaled aftertouch
// level using a moving average over DEPTH gains.
// ---------------------------------------------------------------------------
// Usage: the input channel carries one distance per item (in_valid,
// in_stall); the output channel returns one item per input with the level
// and a flag saying whether the sample entered the ring (out_valid,
// out_stall). Configuration is written through cfg_write, cfg_index and
// cfg_data while the block is idle.
// Each item uses one serial divider at most twice, for the gain and for the
// rescale; the mean comes from a single reciprocal multiplication. A zero or
// out-of-range distance whose mean clamps skips both divisions. The next
// item is accepted in the cycle after the result is registered.
// While the receiver stalls, the result holds in the output register and
// the next item may be accepted and processed up to its output step.
// Reset clears the gain ring, the running sum and the write slot, empties
// the output register and restores the configuration defaults.
// ---------------------------------------------------------------------------
module distance_aftertouch_averager #(
  parameter int DEPTH = daa_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [daa_pkg::IDX_W-1:0]  cfg_index,
  input  logic [daa_pkg::GAIN_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [daa_pkg::DIST_W-1:0] distance,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [daa_pkg::LVL_W-1:0]  aftertouch,
  output logic                       sample_taken
);
  import daa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  daa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  daa_path #(
    .DEPTH (DEPTH)
  ) u_path (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .distance     (distance),
    .cmd          (cmd),
    .sts          (sts),
    .aftertouch   (aftertouch),
    .sample_taken (sample_taken)
  );

endmodule

[design/daa_div.sv]
// ---------------------------------------------------------------------------
// Serial divider
// Restoring divider producing one quotient bit per cycle, for quotients
// known to fit in sixteen bits.
// ---------------------------------------------------------------------------
module daa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [daa_pkg::DIV_W-1:0] num_hi,
  input  logic [daa_pkg::DIV_W-1:0] num_lo,
  input  logic [daa_pkg::DIV_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [daa_pkg::DIV_W-1:0] quotient
);
  import daa_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W-1:0] lo;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W:0]   trial;
  logic             q_bit;

  always_comb begin
    trial    = {rem, lo[DIV_W-1]};
    q_bit    = trial >= {1'b0, den_r};
    rem_next = q_bit ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num_hi;
      lo       <= num_lo;
      den_r    <= den;
      quotient <= '0;
    end else if (busy) begin
      rem      <= rem_next;
      lo       <= {lo[DIV_W-2:0], 1'b0};
      quotient <= {quotient[DIV_W-2:0], q_bit};
    end
  end

endmodule

[design/daa_path.sv]
// ---------------------------------------------------------------------------
// Averager datapath
// Configuration registers, gain ring with running sum, shared divider and
// the output register.
// ---------------------------------------------------------------------------
`include "distance_aftertouch_averager_defines.svh"

module daa_path #(
  parameter int DEPTH = daa_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [daa_pkg::IDX_W-1:0]  cfg_index,
  input  logic [daa_pkg::GAIN_W-1:0] cfg_data,
  input  logic [daa_pkg::DIST_W-1:0] distance,
  input  daa_pkg::cmd_t              cmd,
  output daa_pkg::sts_t              sts,
  output logic [daa_pkg::LVL_W-1:0]  aftertouch,
  output logic                       sample_taken
);
  import daa_pkg::*;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = GAIN_W + $clog2(DEPTH);

  // The mean is the sum times a rounded-up reciprocal of DEPTH; the shift
  // is wide enough for the product to truncate exactly over the sum's range.
  localparam int RECIP_SH = SUM_W + $clog2(DEPTH);
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  logic [DIST_W-1:0] max_distance;
  logic [GAIN_W-1:0] zero_bound;
  logic [GAIN_W-1:0] full_bound;
  logic [DIST_W-1:0] dist_held;
  logic [GAIN_W-1:0] ring [DEPTH];
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  sum;
  logic [GAIN_W-1:0] mean;
  logic [PROD_W-1:0] mean_prod;
  logic [GAIN_W-1:0] gain_new;
  logic [DIV_W-1:0]  num_hi;
  logic [DIV_W-1:0]  num_lo;
  logic [DIV_W-1:0]  den;
  logic [DIV_W-1:0]  quotient;
  logic              div_busy;
  logic              div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= MAX_DISTANCE_RST;
      zero_bound   <= ZERO_BOUND_RST;
      full_bound   <= FULL_BOUND_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_DISTANCE: max_distance <= cfg_data[DIST_W-1:0];
        REG_ZERO_BOUND:   zero_bound   <= cfg_data;
        REG_FULL_BOUND:   full_bound   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gain_new  = cmd.gain_zero ? '0 : quotient;
  assign mean_prod = PROD_W'(sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring[i] <= '0;
      end
      slot <= '0;
      sum  <= '0;
    end else if (cmd.write_gain) begin
      ring[slot] <= gain_new;
      sum        <= sum - SUM_W'(ring[slot]) + SUM_W'(gain_new);
      slot       <= (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
    end
  end

  always_comb begin
    case (cmd.div_op)
      OP_GAIN: begin
        num_hi = DIV_W'(max_distance - dist_held);
        num_lo = '0;
        den    = DIV_W'(max_distance);
      end
      OP_SCALE: begin
        num_hi = mean - zero_bound;
        num_lo = '0;
        den    = full_bound - zero_bound;
      end
      default: begin
        num_hi = '0;
        num_lo = '0;
        den    = DIV_W'(1);
      end
    endcase
  end

  daa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num_hi   (num_hi),
    .num_lo   (num_lo),
    .den      (den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dist_held <= distance;
    end
    if (cmd.mean_load) begin
      mean <= GAIN_W'(mean_prod >> RECIP_SH);
    end
    if (cmd.out_load) begin
      sample_taken <= (dist_held != '0);
      case (cmd.out_src)
        SRC_ZERO: aftertouch <= '0;
        SRC_FULL: aftertouch <= FULL_SCALE;
        SRC_QUOT: aftertouch <= LVL_W'(quotient);
        default:  aftertouch <= '0;
      endcase
    end
  end

  always_comb begin
    sts.dist_zero = (dist_held == '0);
    sts.dist_over = (dist_held > max_distance);
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.mean_low  = (mean <= zero_bound);
    sts.mean_high = (mean >= full_bound);
  end

  `DAA_ASSERT_NXT(a_level_range, cmd.out_load, aftertouch <= FULL_SCALE,
    "Aftertouch level loaded above full scale.")
  `DAA_ASSERT_IMP(a_slot_range, 1'b1, slot <= SLOT_W'(DEPTH - 1),
    "Write slot outside the ring.")
  `DAA_ASSERT_IMP(a_scale_span, cmd.div_start && cmd.div_op == OP_SCALE,
    mean > zero_bound && mean < full_bound,
    "Rescale started with the mean outside the bounds.")

endmodule

[design/daa_ctrl.sv]
// ---------------------------------------------------------------------------
// Averager controller
// Sequences capture, gain division, ring update, mean, rescale and output.
// ---------------------------------------------------------------------------
`include "distance_aftertouch_averager_defines.svh"

module daa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  daa_pkg::sts_t sts,
  output daa_pkg::cmd_t cmd
);
  import daa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_GAIN  = 3'd2;
  localparam logic [2:0] S_MEAN  = 3'd3;
  localparam logic [2:0] S_BOUND = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] src;
  logic [1:0] src_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    src_next       = src;
    cmd            = '0;
    cmd.div_op     = OP_GAIN;
    cmd.out_src    = src;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.dist_zero) begin
          state_next = S_MEAN;
        end else if (sts.dist_over) begin
          cmd.write_gain = 1'b1;
          cmd.gain_zero  = 1'b1;
          state_next     = S_MEAN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_GAIN;
          state_next    = S_GAIN;
        end
      end
      S_GAIN: begin
        if (sts.div_done) begin
          cmd.write_gain = 1'b1;
          state_next     = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_load = 1'b1;
        state_next    = S_BOUND;
      end
      S_BOUND: begin
        if (sts.mean_low) begin
          src_next   = SRC_ZERO;
          state_next = S_OUT;
        end else if (sts.mean_high) begin
          src_next   = SRC_FULL;
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_SCALE;
          src_next      = SRC_QUOT;
          state_next    = S_SCALE;
        end
      end
      S_SCALE: begin
        if (sts.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      src       <= SRC_ZERO;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      src   <= src_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DAA_ASSERT_IMP(a_start_idle, cmd.div_start, !sts.div_busy,
    "Divider started while still busy.")
  `DAA_ASSERT_IMP(a_load_free, cmd.out_load, out_free,
    "Output register overwritten while its item is stalled.")
  `DAA_ASSERT_IMP(a_done_state, sts.div_done,
    state == S_GAIN || state == S_SCALE,
    "Divider finished outside a division state.")

endmodule

[tb/tb_distance_aftertouch_averager.sv]
// ---------------------------------------------------------------------------
// Distance aftertouch averager testbench
// Drives distance items through the averager under several register
// settings, predicts every aftertouch item from a private model of the
// gain ring and the bound rescale, and compares each output item in order.
// Both channels idle at random, and the receiver holds off for one long
// stretch so that the block backs up and stalls its input.
// ---------------------------------------------------------------------------
module tb_distance_aftertouch_averager;
  timeunit 1ns;
  timeprecision 1ps;

  import daa_pkg::*;

  localparam int RING = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             taken;
  } level_t;

  class aftertouch_scoreboard;
    logic [DIST_W-1:0] max_dist;
    logic [GAIN_W-1:0] zero_bnd;
    logic [GAIN_W-1:0] full_bnd;
    logic [GAIN_W-1:0] gains[RING];
    int unsigned next_slot;
    level_t levels_due[$];
    int mismatches;
    int results;
    int items;
    int no_echo;
    int far_hits;
    int clamped;

    function void reset_state();
      foreach (gains[i]) gains[i] = '0;
      next_slot = 0;
      max_dist  = MAX_DISTANCE_RST;
      zero_bnd  = ZERO_BOUND_RST;
      full_bnd  = FULL_BOUND_RST;
      levels_due.delete();
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] v);
      case (idx)
        REG_MAX_DISTANCE: max_dist = v[DIST_W-1:0];
        REG_ZERO_BOUND:   zero_bnd = v;
        REG_FULL_BOUND:   full_bnd = v;
        default: ;
      endcase
    endfunction

    function logic [GAIN_W-1:0] gain_for(logic [DIST_W-1:0] d);
      int unsigned md;
      int unsigned q;
      md = max_dist;
      if (d > max_dist || md == 0) return '0;
      q = ((md - d) * 32'd65536) / md;
      return q[GAIN_W-1:0];
    endfunction

    function logic [LVL_W-1:0] level_for(int unsigned mean);
      longint unsigned num;
      longint unsigned den;
      if (mean <= zero_bnd) return '0;
      if (mean >= full_bnd) return FULL_SCALE;
      num = longint'(mean - zero_bnd) * 64'd65536;
      den = full_bnd - zero_bnd;
      return LVL_W'(num / den);
    endfunction

    function void note_input(logic [DIST_W-1:0] d);
      int unsigned sum;
      level_t e;
      items++;
      e.taken = (d != 0);
      if (d == 0) begin
        no_echo++;
      end else begin
        if (d > max_dist) far_hits++;
        if (next_slot >= RING) next_slot = 0;
        gains[next_slot] = gain_for(d);
        next_slot = (next_slot + 1) % RING;
      end
      sum = 0;
      foreach (gains[i]) sum += gains[i];
      e.level = level_for(sum / RING);
      if (e.level == 0 || e.level == FULL_SCALE) clamped++;
      levels_due.push_back(e);
    endfunction

    function void report(string what, longint unsigned exp_v, longint unsigned act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endfunction

    function void check_result(logic [LVL_W-1:0] lvl, logic tk);
      level_t e;
      results++;
      if (levels_due.size() == 0) begin
        report("unexpected item, aftertouch", 0, lvl);
        return;
      end
      e = levels_due.pop_front();
      if (lvl !== e.level) report("aftertouch", e.level, lvl);
      if (tk !== e.taken) report("sample_taken", e.taken, tk);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [GAIN_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [DIST_W-1:0]   distance = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LVL_W-1:0]    aftertouch;
  logic                sample_taken;

  aftertouch_scoreboard sb = new;
  bit steady = 1'b0;
  bit held = 1'b0;
  int hold_left = 0;
  int settings = 0;
  int cycles = 0;

  distance_aftertouch_averager DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .distance(distance),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .aftertouch(aftertouch),
    .sample_taken(sample_taken)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(aftertouch, sample_taken);
  end

  // The receiver holds off once for a long stretch after enough items have come out.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held && sb.results >= 900) begin
      held = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 36);
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_regs(input logic [GAIN_W-1:0] md, input logic [GAIN_W-1:0] zb,
                          input logic [GAIN_W-1:0] fb);
    write_reg(REG_MAX_DISTANCE, md);
    write_reg(REG_ZERO_BOUND, zb);
    write_reg(REG_FULL_BOUND, fb);
    settings++;
  endtask

  task automatic send_item(input logic [DIST_W-1:0] d);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    distance <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(d);
  endtask

  task automatic send_batch(input logic [DIST_W-1:0] ds[$]);
    foreach (ds[i]) send_item(ds[i]);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.levels_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DIST_W-1:0] pick_distance(int unsigned md);
    int unsigned r;
    int unsigned top;
    int near_d;
    r = $urandom_range(99);
    top = (md == 0) ? 1 : md;
    if (r < 10) return '0;
    if (r < 55) return DIST_W'($urandom_range(top, 1));
    if (r < 75) begin
      near_d = int'(top) + int'($urandom_range(4)) - 2;
      if (near_d < 1) near_d = 1;
      if (near_d > 4095) near_d = 4095;
      return DIST_W'(near_d);
    end
    return DIST_W'($urandom_range(4095, 1));
  endfunction

  task automatic random_phase(input int n);
    logic [DIST_W-1:0] ds[$];
    repeat (n) ds.push_back(pick_distance(sb.max_dist));
    send_batch(ds);
  endtask

  initial begin
    logic [GAIN_W-1:0] a;
    logic [GAIN_W-1:0] b;
    sb.reset_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settings = 1;

    // Reset defaults: no echo on an empty ring, beyond and at max, then a full ring.
    send_batch('{12'd0, 12'd4095, 12'd400, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1,
                 12'd399, 12'd0});

    set_regs(16'hFFFF, 16'd0, 16'd65535);
    write_reg(REG_SPARE, 16'hFFFF);
    send_batch('{12'd2048, 12'hAAA, 12'h555, 12'd4095, 12'd0});

    // Zero max distance with crossed bounds.
    set_regs(16'hF000, 16'd65535, 16'd0);
    send_batch('{12'd1, 12'd4095, 12'd0});

    // Equal bounds.
    set_regs(16'h0001, 16'd100, 16'd100);
    send_batch('{12'd1, 12'd2, 12'd0});

    set_regs(MAX_DISTANCE_RST, ZERO_BOUND_RST, FULL_BOUND_RST);
    random_phase(330);

    steady = 1'b1;
    set_regs(16'hFFFF, 16'd0, 16'd65535);
    random_phase(350);
    steady = 1'b0;

    set_regs({4'($urandom), 12'd1}, 16'($urandom), 16'($urandom));
    random_phase(250);

    a = 16'($urandom);
    set_regs({4'($urandom), 12'($urandom_range(4095, 1))}, a, 16'($urandom_range(a)));
    random_phase(250);

    a = 16'($urandom);
    b = 16'($urandom);
    set_regs({4'($urandom), 12'($urandom_range(4095, 1))},
             (a < b) ? a : b, (a < b) ? b : a);
    random_phase(300);

    a = 16'($urandom_range(20000));
    b = 16'($urandom_range(65535, 40000));
    set_regs(16'($urandom_range(64, 1)), a, b);
    random_phase(330);

    repeat (60) @(posedge clk);
    $display("Checked %0d output items against %0d input items over %0d register settings.",
             sb.results, sb.items, settings);
    $display("%0d items had no echo, %0d lay beyond max_distance, %0d levels were clamped.",
             sb.no_echo, sb.far_hits, sb.clamped);
    if (sb.mismatches == 0 && sb.levels_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d items still expected", sb.mismatches,
               sb.levels_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[distance_aftertouch_averager.f]
+incdir+design
design/daa_pkg.sv
design/daa_div.sv
design/daa_path.sv
design/daa_ctrl.sv
design/distance_aftertouch_averager.sv
tb/tb_distance_aftertouch_averager.sv
